[design/spq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Queue depth, counter widths, command and status codes, beat payloads.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 128;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_TREAT = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_PRIO = 2'd3
  } status_t;

  localparam logic [2:0] PRIO_CRITICAL = 3'd1;
  localparam logic [2:0] PRIO_SERIOUS  = 3'd2;
  localparam logic [2:0] PRIO_NORMAL   = 3'd3;

  // One stored case
  typedef struct packed {
    logic [15:0] case_id;
    logic [31:0] tag;
    logic [1:0]  prio;
  } entry_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic       ins;
    logic       rem;
    logic [1:0] new_prio;
    entry_t     new_entry;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] case_id;
    logic [31:0] patient_tag;
    logic [2:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] served_case_id;
    logic [31:0] served_tag;
    logic [1:0]  served_priority;
    logic        head_valid;
    logic [15:0] head_case_id;
    logic [31:0] head_tag;
    logic [1:0]  head_priority;
    logic [7:0]  total_count;
    logic [7:0]  critical_count;
    logic [7:0]  serious_count;
    logic [7:0]  normal_count;
  } out_item_t;

endpackage
`default_nettype wire

[design/spq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift-register queue
// Holds one entry, flags whether the new case lands at or before this slot,
// and on an add or treat takes data from its left or right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  wire logic                     clk,
  input  wire spq_pkg::cell_ctl_t       ctl,
  input  wire logic [spq_pkg::IDX_W-1:0] cell_idx,
  input  wire logic [spq_pkg::CNT_W-1:0] count,
  input  wire spq_pkg::entry_t          left_entry,
  input  wire logic                     left_take,
  input  wire spq_pkg::entry_t          right_entry,
  output spq_pkg::entry_t               entry,
  output logic                          take
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;

  // Slot is live when its index lies below the fill count
  assign occupied = CNT_W'(cell_idx) < count;

  // New case goes behind every live entry of equal or better priority
  assign take = !occupied || (entry_r.prio > ctl.new_prio);

  // Pick next content: shift right on insert, shift left on removal
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (take && left_take) begin
        entry_nxt = left_entry;
      end else if (take) begin
        entry_nxt = ctl.new_entry;
      end
    end else if (ctl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

[design/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue: three-level priority queue with arrival-order ties
// The result beat is registered and appears in the cycle after the command beat.
// Throughput: one command per cycle while out_ready holds; every cell compares and shifts at once.
// Reset: fill count, level counters and out_valid clear; slot contents stay as they are
// and are only read below the fill count. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module stable_priority_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spq_pkg::out_item_t      out_data
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [CNT_W-1:0] crit_r,   crit_nxt;
  logic [CNT_W-1:0] ser_r,    ser_nxt;
  logic [CNT_W-1:0] norm_r,   norm_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r, out_data_nxt;

  logic      accept;
  logic      is_add, is_treat;
  logic      full, empty, prio_ok;
  logic      do_ins, do_rem;
  logic      ins_at_head;
  logic [1:0] new_prio;
  cell_ctl_t ctl;
  entry_t    new_entry;
  entry_t    cell_q [DEPTH];
  logic      take   [DEPTH];
  entry_t    head_after;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  // Decode the command beat
  assign is_add   = in_data.command == CMD_ADD;
  assign is_treat = in_data.command == CMD_TREAT;
  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign prio_ok  = (in_data.priority_req == PRIO_CRITICAL) ||
                    (in_data.priority_req == PRIO_SERIOUS)  ||
                    (in_data.priority_req == PRIO_NORMAL);
  assign do_ins   = accept && is_add && !full && prio_ok;
  assign do_rem   = accept && is_treat && !empty;
  assign new_prio = in_data.priority_req[1:0];

  assign new_entry.case_id = in_data.case_id;
  assign new_entry.tag     = in_data.patient_tag;
  assign new_entry.prio    = new_prio;

  assign ctl.ins       = do_ins;
  assign ctl.rem       = do_rem;
  assign ctl.new_prio  = new_prio;
  assign ctl.new_entry = new_entry;

  // Row of cells, slot 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cell_idx    (IDX_W'(i)),
      .count       (count_r),
      .left_entry  ((i == 0) ? new_entry : cell_q[(i == 0) ? 0 : i - 1]),
      .left_take   ((i == 0) ? 1'b0 : take[(i == 0) ? 0 : i - 1]),
      .right_entry (cell_q[(i == DEPTH - 1) ? i : i + 1]),
      .entry       (cell_q[i]),
      .take        (take[i])
    );
  end

  // Advance fill count and per-level counters
  always_comb begin
    count_nxt = count_r;
    crit_nxt  = crit_r;
    ser_nxt   = ser_r;
    norm_nxt  = norm_r;
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
      if (new_prio == PRIO_CRITICAL[1:0]) begin
        crit_nxt = crit_r + 1'b1;
      end else if (new_prio == PRIO_SERIOUS[1:0]) begin
        ser_nxt = ser_r + 1'b1;
      end else begin
        norm_nxt = norm_r + 1'b1;
      end
    end else if (do_rem) begin
      count_nxt = count_r - 1'b1;
      if (cell_q[0].prio == PRIO_CRITICAL[1:0] && crit_r != '0) begin
        crit_nxt = crit_r - 1'b1;
      end else if (cell_q[0].prio == PRIO_SERIOUS[1:0] && ser_r != '0) begin
        ser_nxt = ser_r - 1'b1;
      end else if (cell_q[0].prio == PRIO_NORMAL[1:0] && norm_r != '0) begin
        norm_nxt = norm_r - 1'b1;
      end
    end
  end

  // Head after the step
  assign ins_at_head = empty || (new_prio < cell_q[0].prio);

  always_comb begin
    head_after = cell_q[0];
    if (do_ins && ins_at_head) begin
      head_after = new_entry;
    end else if (do_rem) begin
      head_after = cell_q[1];
    end
  end

  // Build the result beat
  always_comb begin
    out_data_nxt = '0;
    if (is_add) begin
      if (full) begin
        out_data_nxt.status = ST_FULL;
      end else if (!prio_ok) begin
        out_data_nxt.status = ST_BAD_PRIO;
      end else begin
        out_data_nxt.status = ST_OK;
      end
    end else if (is_treat) begin
      if (empty) begin
        out_data_nxt.status = ST_EMPTY;
      end else begin
        out_data_nxt.status          = ST_OK;
        out_data_nxt.served_case_id  = cell_q[0].case_id;
        out_data_nxt.served_tag      = cell_q[0].tag;
        out_data_nxt.served_priority = cell_q[0].prio;
      end
    end else begin
      out_data_nxt.status = ST_OK;
    end
    if (count_nxt != '0) begin
      out_data_nxt.head_valid    = 1'b1;
      out_data_nxt.head_case_id  = head_after.case_id;
      out_data_nxt.head_tag      = head_after.tag;
      out_data_nxt.head_priority = head_after.prio;
    end
    out_data_nxt.total_count    = 8'(count_nxt);
    out_data_nxt.critical_count = 8'(crit_nxt);
    out_data_nxt.serious_count  = 8'(ser_nxt);
    out_data_nxt.normal_count   = 8'(norm_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crit_r      <= '0;
      ser_r       <= '0;
      norm_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
        crit_r  <= crit_nxt;
        ser_r   <= ser_nxt;
        norm_r  <= norm_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Level counters always add up to the fill count
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W + 2)'(crit_r) + (CNT_W + 2)'(ser_r) + (CNT_W + 2)'(norm_r)
      == (CNT_W + 2)'(count_r))
    else $error("level counters disagree with fill count");

  // Fill count never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  // A good add grows the queue by one
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> count_r == $past(count_r) + 1'b1)
    else $error("add did not grow the queue");

  // A live head always carries a valid level
  a_head_prio: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> cell_q[0].prio != 2'd0)
    else $error("head holds level zero");

endmodule
`default_nettype wire
